// File: rtl/keyboard_mouse_event_decoder_core_defines.svh
// Assertion macros for the keyboard and mouse event decoder RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef KEYBOARD_MOUSE_EVENT_DECODER_CORE_DEFINES_SVH
`define KEYBOARD_MOUSE_EVENT_DECODER_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define KMED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define KMED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/kmed_pkg.sv
// Types and codes for the keyboard and mouse event decoder.
// No dependencies.
package kmed_pkg;

    localparam logic [7:0] MOUSE_CODE    = 8'h7e;
    localparam logic [7:0] CMD_PRESS     = 8'h37;
    localparam logic [7:0] CMD_RELEASE   = 8'hb7;
    localparam logic [7:0] SHIFT_PRESS   = 8'h38;
    localparam logic [7:0] SHIFT_RELEASE = 8'hb8;
    localparam logic [7:0] CAPS_PRESS    = 8'h39;
    localparam logic [7:0] CAPS_RELEASE  = 8'hb9;
    localparam logic [7:0] OPT_PRESS     = 8'h3a;
    localparam logic [7:0] OPT_RELEASE   = 8'hba;
    localparam logic [7:0] CTRL_PRESS    = 8'h36;
    localparam logic [7:0] CTRL_RELEASE  = 8'hb6;

    localparam int MOD_SHIFT = 0;
    localparam int MOD_CAPS  = 1;
    localparam int MOD_OPT   = 2;
    localparam int MOD_CTRL  = 3;
    localparam int MOD_CMD   = 4;

    localparam int EV_BUT = 0;
    localparam int EV_MOV = 1;
    localparam int EV_KEY = 2;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 128;

    typedef struct packed {
        logic [7:0]  event_code;
        logic [7:0]  mouse_x_byte;
        logic [7:0]  mouse_y_byte;
        logic [31:0] now_ticks;
    } t_event;

    typedef struct packed {
        logic [2:0]  event_mask;
        logic        mouse_enable;
        logic [7:0]  key_code;
        logic [15:0] modifier_flags;
        logic [15:0] cursor_x;
        logic [15:0] cursor_y;
        logic        button_down;
        logic [31:0] button_tick;
        logic [31:0] button_tick_alt;
    } t_result;

    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage

// File: rtl/kmed_in_stage.sv
// Input register of the event decoder: holds one accepted item.
// Depends on kmed_pkg.
module kmed_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic                  i_advance,
    input  kmed_pkg::t_event      i_item,
    output kmed_pkg::t_event      o_item,
    output logic                  o_valid
);
    import kmed_pkg::*;

    logic   r_valid;
    t_event r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

// File: rtl/kmed_state.sv
// Decoder state and its single-pass update for one event.
// Depends on kmed_pkg and keyboard_mouse_event_decoder_core_defines.svh.
module kmed_state (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  kmed_pkg::t_stage_ctl  i_ctl,
    input  kmed_pkg::t_event      i_item,
    output kmed_pkg::t_result     o_res
);
    import kmed_pkg::*;
    `include "keyboard_mouse_event_decoder_core_defines.svh"

    logic [4:0]  r_mod,   n_mod;
    logic [7:0]  r_key,   n_key;
    logic        r_btn,   n_btn;
    logic [31:0] r_stamp, n_stamp;
    logic [31:0] r_alt,   n_alt;
    logic [15:0] r_cx,    n_cx;
    logic [15:0] r_cy,    n_cy;
    logic [2:0]  mask;
    logic        is_mouse;
    logic        lvl;

    assign is_mouse = (i_item.event_code == MOUSE_CODE);
    assign lvl      = i_item.mouse_x_byte[7];

    always_comb begin
        n_mod   = r_mod;
        n_key   = r_key;
        n_btn   = r_btn;
        n_stamp = r_stamp;
        n_alt   = r_alt;
        n_cx    = r_cx;
        n_cy    = r_cy;
        mask    = '0;
        if (is_mouse) begin
            if (lvl != r_btn) begin
                n_btn        = lvl;
                n_stamp      = i_item.now_ticks;
                n_alt        = r_alt + (i_item.now_ticks - r_stamp);
                mask[EV_BUT] = 1'b1;
            end
            mask[EV_MOV] = (i_item.mouse_x_byte[6:0] != 7'd0) ||
                           (i_item.mouse_y_byte[6:0] != 7'd0);
            n_cx = r_cx + {{9{i_item.mouse_x_byte[6]}}, i_item.mouse_x_byte[6:0]};
            n_cy = r_cy + {{9{i_item.mouse_y_byte[6]}}, i_item.mouse_y_byte[6:0]};
        end else begin
            case (i_item.event_code)
                CMD_PRESS:     n_mod[MOD_CMD]   = 1'b1;
                CMD_RELEASE:   n_mod[MOD_CMD]   = 1'b0;
                SHIFT_PRESS:   n_mod[MOD_SHIFT] = 1'b1;
                SHIFT_RELEASE: n_mod[MOD_SHIFT] = 1'b0;
                CAPS_PRESS:    n_mod[MOD_CAPS]  = 1'b1;
                CAPS_RELEASE:  n_mod[MOD_CAPS]  = 1'b0;
                OPT_PRESS:     n_mod[MOD_OPT]   = 1'b1;
                OPT_RELEASE:   n_mod[MOD_OPT]   = 1'b0;
                CTRL_PRESS:    n_mod[MOD_CTRL]  = 1'b1;
                CTRL_RELEASE:  n_mod[MOD_CTRL]  = 1'b0;
                default: begin
                    n_key        = i_item.event_code;
                    mask[EV_KEY] = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod   <= '0;
            r_key   <= '0;
            r_btn   <= 1'b0;
            r_stamp <= '0;
            r_alt   <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
        end else if (i_ctl.advance) begin
            r_mod   <= n_mod;
            r_key   <= n_key;
            r_btn   <= n_btn;
            r_stamp <= n_stamp;
            r_alt   <= n_alt;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
        end
    end

    always_comb begin
        o_res.event_mask      = mask;
        o_res.mouse_enable    = mask[EV_MOV];
        o_res.key_code        = n_key;
        o_res.modifier_flags  = {n_mod[MOD_CMD], 11'd0, n_mod[3:0]};
        o_res.cursor_x        = n_cx;
        o_res.cursor_y        = n_cy;
        o_res.button_down     = n_btn;
        o_res.button_tick     = n_stamp;
        o_res.button_tick_alt = n_alt;
    end

    `KMED_ASSERT_NOW(a_adv_needs_valid, i_ctl.advance, i_ctl.valid, "advance without item")
    `KMED_ASSERT_NEXT(a_key_keeps_cursor, i_ctl.advance && !is_mouse,
                      $stable(r_cx) && $stable(r_cy) && $stable(r_btn), "key event moved mouse")
    `KMED_ASSERT_NEXT(a_mouse_keeps_keys, i_ctl.advance && is_mouse,
                      $stable(r_key) && $stable(r_mod), "mouse event changed keys")
    `KMED_ASSERT_NEXT(a_button_flag, i_ctl.advance && mask[EV_BUT],
                      r_btn != $past(r_btn), "button flag without change")
    `KMED_ASSERT_NEXT(a_idle_holds, !i_ctl.advance,
                      $stable(r_stamp) && $stable(r_alt) && $stable(r_cx), "state moved while idle")

endmodule

// File: rtl/keyboard_mouse_event_decoder_core.sv
// Pipeline: input register, then result register; o_m_tvalid rises once an accepted item has
// been registered in both, and the result is held until it is taken.
// Throughput: one item per cycle; the input side drops ready only when both registers hold an
// item and the result is not taken.
// Reset: synchronous, active low; clears all decoder state and both valid flags.
// Depends on kmed_pkg, kmed_in_stage and kmed_state.
module keyboard_mouse_event_decoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // event_code, mouse_x_byte, mouse_y_byte, now_ticks
    input  logic [kmed_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // event_mask, mouse_enable, key_code, modifier_flags, cursor_x, cursor_y,
    // button_down, button_tick, button_tick_alt, zero pad
    output logic [kmed_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import kmed_pkg::*;

    t_event     in_item;
    t_event     stage_item;
    t_result    res;
    t_stage_ctl ctl;
    logic       stage_valid;
    logic       advance;
    logic       load;
    logic       r_out_valid;
    t_result    r_out;

    assign in_item = '{event_code:   i_s_tdata[7:0],
                       mouse_x_byte: i_s_tdata[15:8],
                       mouse_y_byte: i_s_tdata[23:16],
                       now_ticks:    i_s_tdata[55:24]};

    assign advance    = stage_valid && (!r_out_valid || i_m_tready);
    assign ctl        = '{valid: stage_valid, advance: advance};
    assign o_s_tready = !stage_valid || advance;
    assign load       = i_s_tvalid && o_s_tready;

    kmed_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_advance (advance),
        .i_item    (in_item),
        .o_item    (stage_item),
        .o_valid   (stage_valid)
    );

    kmed_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_item  (stage_item),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out.button_tick_alt, r_out.button_tick, r_out.button_down,
                         r_out.cursor_y, r_out.cursor_x, r_out.modifier_flags,
                         r_out.key_code, r_out.mouse_enable, r_out.event_mask};

endmodule
